FILE: rtl/core/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Command and status codes, message word constants and shared helpers for
// the multi-queue message FIFO.
// ----------------------------------------------------------------------------
package mqf_pkg;

  // Message word geometry
  localparam int MSG_W  = 64;
  localparam int MSG_NB = MSG_W / 8;
  localparam int FC_W   = 5;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  // Commands
  localparam cmd_t CMD_CREATE  = 2'd0;
  localparam cmd_t CMD_DELETE  = 2'd1;
  localparam cmd_t CMD_SEND    = 2'd2;
  localparam cmd_t CMD_RECEIVE = 2'd3;

  // Result status
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_ID  = 2'd1;
  localparam status_t ST_BUSY    = 2'd2;
  localparam status_t ST_NO_FREE = 2'd3;

  // Message store port control
  typedef struct packed {
    logic wr;
    logic rd;
  } mqf_store_ctl_t;

  // Keep the low nbytes bytes of a message word
  function automatic logic [MSG_W-1:0] byte_mask(input logic [3:0] nbytes);
    logic [MSG_W-1:0] m;
    m = '0;
    for (int b = 0; b < MSG_NB; b++) begin
      if (4'(b) < nbytes) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/mqf_msg_store.sv
// ----------------------------------------------------------------------------
// mqf_msg_store
// Single-port message store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module mqf_msg_store
  import mqf_pkg::*;
#(
  parameter int WORDS  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                  clk,
  input  mqf_store_ctl_t        ctl,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [MSG_W-1:0]      wr_data,
  output logic [MSG_W-1:0]      rd_data
);

  logic [MSG_W-1:0] mem [WORDS];

  // Write on send, register read data on receive
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/multi_queue_message_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_message_fifo
// Bank of independent ring-buffer message queues sharing one message store.
// ----------------------------------------------------------------------------
// Every transfer carries one command (create, delete, send, receive) and
// yields exactly one result in the cycle after it; a new command can be taken
// in every cycle while results are taken, so the sustained rate is one item
// per clock. The latency is set by the registered read port of the message
// store, which is read or written at most once per command. Queue bookkeeping
// lives in flip-flops cleared by reset; the message store itself is not
// cleared (no clearing pass), and a receive only ever reads entries written
// by a send after the queue was created. The input is held off only while a
// result waits to be taken.
module multi_queue_message_fifo
  import mqf_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int DEPTH      = 16,
  parameter int MSG_BYTES  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [3:0]         target_id,
  input  logic [7:0]         size_request,
  input  logic [15:0]        depth_request,
  input  logic [63:0]        payload,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [3:0]         new_id,
  output logic [63:0]        read_data,
  output logic [4:0]         fill_count
);

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int MBW    = $clog2(MSG_BYTES + 1);
  localparam int WORDS  = NUM_QUEUES * DEPTH;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Per-queue bookkeeping
  logic           slot_used      [NUM_QUEUES];
  logic [PW-1:0]  write_ptr      [NUM_QUEUES];
  logic [PW-1:0]  read_ptr       [NUM_QUEUES];
  logic [CW-1:0]  fill           [NUM_QUEUES];
  logic [CW-1:0]  queue_capacity [NUM_QUEUES];
  logic [MBW-1:0] queue_msg_bytes[NUM_QUEUES];

  // Result register
  logic [1:0]       result_status;
  logic [3:0]       result_id;
  logic [FC_W-1:0]  result_fill;
  logic [MSG_W-1:0] result_mask;
  logic [MSG_W-1:0] rd_data;

  logic           acc;
  logic [QW-1:0]  qidx;
  logic           id_ok;
  logic           free_found;
  logic [QW-1:0]  free_idx;
  logic [PW-1:0]  cur_wp, cur_rp;
  logic [CW-1:0]  cur_fill, cur_cap;
  logic [MBW-1:0] cur_mb;

  logic           upd_en;
  logic [QW-1:0]  upd_idx;
  logic           used_next;
  logic [PW-1:0]  wp_next, rp_next;
  logic [CW-1:0]  fill_next, cap_next;
  logic [MBW-1:0] mb_next;

  logic [1:0]       status_next;
  logic [3:0]       new_id_next;
  logic [CW-1:0]    count_next;
  logic [MSG_W-1:0] mask_next;

  mqf_store_ctl_t    store_ctl;
  logic [ADDR_W-1:0] store_addr;
  logic [MSG_W-1:0]  store_wdata;

  // Step a ring pointer, wrapping at the queue's capacity
  function automatic logic [PW-1:0] ptr_advance(input logic [PW-1:0] p,
                                                input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx = CW'(p) + CW'(1);
    return (nx >= cap) ? '0 : PW'(nx);
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  // Look up the addressed queue
  assign qidx     = target_id[QW-1:0];
  assign id_ok    = (5'(target_id) < 5'(NUM_QUEUES)) && slot_used[qidx];
  assign cur_wp   = write_ptr[qidx];
  assign cur_rp   = read_ptr[qidx];
  assign cur_fill = fill[qidx];
  assign cur_cap  = queue_capacity[qidx];
  assign cur_mb   = queue_msg_bytes[qidx];

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  // Decode the command into a queue update, a store access and a result
  always_comb begin
    upd_en      = 1'b0;
    upd_idx     = qidx;
    used_next   = 1'b1;
    wp_next     = cur_wp;
    rp_next     = cur_rp;
    fill_next   = cur_fill;
    cap_next    = cur_cap;
    mb_next     = cur_mb;
    status_next = ST_OK;
    new_id_next = '0;
    count_next  = '0;
    mask_next   = '0;
    store_ctl   = '0;
    store_addr  = ADDR_W'(qidx) * ADDR_W'(DEPTH) + ADDR_W'(cur_wp);
    store_wdata = payload & byte_mask(4'(cur_mb));
    if (cmd == CMD_CREATE) begin
      if (free_found) begin
        upd_en      = acc;
        upd_idx     = free_idx;
        wp_next     = '0;
        rp_next     = '0;
        fill_next   = '0;
        cap_next    = (depth_request > 16'(DEPTH)) ? CW'(DEPTH) : CW'(depth_request);
        mb_next     = (size_request > 8'(MSG_BYTES)) ? MBW'(MSG_BYTES)
                                                     : MBW'(size_request);
        new_id_next = 4'(free_idx);
      end else begin
        status_next = ST_NO_FREE;
      end
    end else if (!id_ok) begin
      status_next = ST_BAD_ID;
    end else begin
      unique case (cmd)
        CMD_DELETE: begin
          upd_en    = acc;
          used_next = 1'b0;
          wp_next   = '0;
          rp_next   = '0;
          fill_next = '0;
          cap_next  = '0;
          mb_next   = '0;
        end
        CMD_SEND: begin
          if (cur_fill >= cur_cap) begin
            status_next = ST_BUSY;
          end else begin
            upd_en       = acc;
            store_ctl.wr = acc;
            wp_next      = ptr_advance(cur_wp, cur_cap);
            fill_next    = cur_fill + CW'(1);
          end
          count_next = fill_next;
        end
        default: begin
          if (cur_fill == '0) begin
            status_next = ST_BUSY;
          end else begin
            upd_en       = acc;
            store_ctl.rd = acc;
            store_addr   = ADDR_W'(qidx) * ADDR_W'(DEPTH) + ADDR_W'(cur_rp);
            rp_next      = ptr_advance(cur_rp, cur_cap);
            fill_next    = cur_fill - CW'(1);
            mask_next    = byte_mask(4'(cur_mb));
          end
          count_next = fill_next;
        end
      endcase
    end
  end

  // Update queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        slot_used[i]       <= 1'b0;
        write_ptr[i]       <= '0;
        read_ptr[i]        <= '0;
        fill[i]            <= '0;
        queue_capacity[i]  <= '0;
        queue_msg_bytes[i] <= '0;
      end
    end else if (upd_en) begin
      slot_used[upd_idx]       <= used_next;
      write_ptr[upd_idx]       <= wp_next;
      read_ptr[upd_idx]        <= rp_next;
      fill[upd_idx]            <= fill_next;
      queue_capacity[upd_idx]  <= cap_next;
      queue_msg_bytes[upd_idx] <= mb_next;
    end
  end

  mqf_msg_store #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .addr    (store_addr),
    .wr_data (store_wdata),
    .rd_data (rd_data)
  );

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      result_status <= status_next;
      result_id     <= new_id_next;
      result_fill   <= FC_W'(count_next);
      result_mask   <= mask_next;
    end
  end

  assign status     = result_status;
  assign new_id     = result_id;
  assign fill_count = result_fill;
  assign read_data  = rd_data & result_mask;

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted command produced no result");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status != ST_OK |-> result_mask == '0 && result_id == '0)
    else $error("failed command carries data or id");

  a_no_free_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_status == ST_NO_FREE || result_status == ST_BAD_ID)
      |-> result_fill == '0)
    else $error("error result carries a fill count");

endmodule
